@@ rtl/rsmp_pkg.sv @@
package rsmp_pkg;

    localparam int SLOTS       = 64;
    localparam int WEIGHT_BITS = 16;

    // index into the weight store and slot counter
    localparam int IDX_W = $clog2(SLOTS);
    // fill count, must hold SLOTS itself
    localparam int CNT_W = $clog2(SLOTS + 1);
    // cumulative sum and threshold carry one integer bit
    localparam int SUM_W = WEIGHT_BITS + 1;
    // remainder of the threshold step, always below SLOTS, plus a carry bit
    localparam int REM_W = IDX_W + 1;

    localparam longint unsigned ONE_UNIT = 64'd1 << WEIGHT_BITS;
    localparam longint unsigned STEP_Q   = ONE_UNIT / SLOTS;
    localparam longint unsigned STEP_R   = ONE_UNIT % SLOTS;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic [15:0] weight;
        logic [9:0]  offset;
        logic        last_weight;
    } rsmp_in_t;

    typedef struct packed {
        logic [5:0] source_index;
        logic [5:0] slot_index;
        logic       last_slot;
    } rsmp_out_t;

    // walk start command from the load side
    typedef struct packed {
        logic             start;
        logic [9:0]       offset;
        logic [IDX_W-1:0] top;
    } rsmp_start_t;

    // read request into the weight store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rsmp_rd_req_t;

    // write request into the weight store
    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       addr;
        logic [WEIGHT_BITS-1:0] data;
    } rsmp_wr_req_t;

endpackage

@@ rtl/rsmp_wstore.sv @@
module rsmp_wstore
    import rsmp_pkg::*;
(
    input  logic                   aclk,
    input  rsmp_wr_req_t           wr_req,
    input  rsmp_rd_req_t           rd_req,
    output logic [WEIGHT_BITS-1:0] rd_data
);

    logic [WEIGHT_BITS-1:0] mem [SLOTS];
    logic [WEIGHT_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rsmp_walk.sv @@
module rsmp_walk
    import rsmp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rsmp_start_t            start,
    output logic                   busy,
    output rsmp_rd_req_t           rd_req,
    input  logic [WEIGHT_BITS-1:0] rd_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rsmp_out_t              m_data
);

    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_RD0  = 3'd1;
    localparam logic [2:0] W_INIT = 3'd2;
    localparam logic [2:0] W_CMP  = 3'd3;
    localparam logic [2:0] W_ADD  = 3'd4;

    localparam logic [WEIGHT_BITS-1:0] Q_STEP = WEIGHT_BITS'(STEP_Q);
    localparam logic [REM_W-1:0]       R_STEP = REM_W'(STEP_R);
    localparam logic [REM_W-1:0]       R_WRAP = REM_W'(SLOTS);
    localparam logic [IDX_W-1:0]       N_LAST = IDX_W'(SLOTS - 1);

    logic [2:0]             state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       top_reg, top_next;
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [9:0]             offset_reg, offset_next;
    logic [WEIGHT_BITS-1:0] base_reg, base_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic                   m_valid_reg, m_valid_next;
    rsmp_out_t              m_data_reg, m_data_next;

    logic [SUM_W-1:0]       thr;
    logic [SUM_W:0]         sum_add;
    logic [REM_W-1:0]       rem_add;
    logic                   out_free;
    logic                   advance;

    assign thr      = SUM_W'(offset_reg) + SUM_W'(base_reg);
    assign sum_add  = {1'b0, sum_reg} + (SUM_W + 1)'(rd_data);
    assign rem_add  = rem_reg + R_STEP;
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = (thr > sum_reg) && (idx_reg != top_reg);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        top_next     = top_reg;
        n_next       = n_reg;
        sum_next     = sum_reg;
        offset_next  = offset_reg;
        base_next    = base_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rd_req.en    = 1'b0;
        rd_req.addr  = idx_reg;

        unique case (state_reg)
            W_IDLE: begin
                if (start.start) begin
                    offset_next = start.offset;
                    top_next    = start.top;
                    idx_next    = '0;
                    n_next      = '0;
                    base_next   = '0;
                    rem_next    = '0;
                    state_next  = W_RD0;
                end
            end
            W_RD0: begin
                rd_req.en   = 1'b1;
                rd_req.addr = '0;
                state_next  = W_INIT;
            end
            W_INIT: begin
                sum_next   = SUM_W'(rd_data);
                state_next = W_CMP;
            end
            W_CMP: begin
                if (advance) begin
                    rd_req.en   = 1'b1;
                    rd_req.addr = idx_reg + 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    state_next  = W_ADD;
                end else if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.source_index = 6'(idx_reg);
                    m_data_next.slot_index   = 6'(n_reg);
                    m_data_next.last_slot    = (n_reg == N_LAST);
                    n_next = n_reg + 1'b1;
                    // next threshold base: floor((n+1) * one / SLOTS)
                    if (rem_add >= R_WRAP) begin
                        rem_next  = rem_add - R_WRAP;
                        base_next = base_reg + Q_STEP + 1'b1;
                    end else begin
                        rem_next  = rem_add;
                        base_next = base_reg + Q_STEP;
                    end
                    if (n_reg == N_LAST) begin
                        state_next = W_IDLE;
                    end
                end
            end
            W_ADD: begin
                sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                state_next = W_CMP;
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= W_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            sum_reg     <= '0;
            n_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            n_reg       <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        offset_reg <= offset_next;
        base_reg   <= base_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
    end

    assign busy    = (state_reg != W_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/systematic_resampler_top.sv @@
// channel   direction  payload                                   handshake
// s_        in         weight, offset, last_weight (rsmp_in_t)   s_valid / s_ready
// m_        out        source_index, slot_index, last_slot       m_valid / m_ready
//
// a weight beat without the last flag is taken as one store write while the store is not full
// a last beat starts the walk: entry 0 is fetched (store read, then sum load),
// then each slot is emitted from the compare state when the result register is
// free; each step of the walk is a store read, then an add, on the single read port
// s_ready is low while the walk runs; the result register decouples m_ready
// aresetn is synchronous, active low; it clears the fill count and walker control
module systematic_resampler_top
    import rsmp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  rsmp_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rsmp_out_t m_data
);

    logic [CNT_W-1:0]       load_count_reg, load_count_next;
    logic                   full;
    logic                   s_fire;
    logic                   walk_busy;
    rsmp_wr_req_t           wr_req;
    rsmp_rd_req_t           rd_req;
    rsmp_start_t            start;
    logic [WEIGHT_BITS-1:0] rd_data;

    // loading and walking never overlap: s_ready is low while the walker holds
    // the store read port, so no forwarding between write and read is needed
    assign s_ready = !walk_busy;
    assign s_fire  = s_valid && s_ready;
    assign full    = (load_count_reg == CNT_W'(SLOTS));

    // weights beyond a full store are dropped
    assign wr_req.en   = s_fire && !full;
    assign wr_req.addr = load_count_reg[IDX_W-1:0];
    assign wr_req.data = s_data.weight[WEIGHT_BITS-1:0];

    // top = index of the last loaded entry, counting this beat
    assign start.start  = s_fire && s_data.last_weight;
    assign start.offset = s_data.offset;
    assign start.top    = full ? IDX_W'(SLOTS - 1) : load_count_reg[IDX_W-1:0];

    always_comb begin
        load_count_next = load_count_reg;
        if (s_fire) begin
            if (s_data.last_weight) begin
                // the set is closed, the next beat starts a new one
                load_count_next = '0;
            end else if (!full) begin
                load_count_next = load_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
        end else begin
            load_count_reg <= load_count_next;
        end
    end

    rsmp_wstore u_wstore (
        .aclk    (aclk),
        .wr_req  (wr_req),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    rsmp_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .busy    (walk_busy),
        .rd_req  (rd_req),
        .rd_data (rd_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
